/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TBS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tbs_pkg.sv */
// ----------------------------------------------------------------------------
// tbs_pkg
// Types and codes shared by the bound smoothing block.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_RUN   = 2'd2;

    localparam logic CFG_MSIZE = 1'b0;
    localparam logic CFG_MAXP  = 1'b1;

    localparam logic [9:0] MAXP_RESET  = 10'd300;
    localparam logic [4:0] MSIZE_RESET = 5'd16;

    // cached entries of one triple i<j<k
    localparam logic [2:0] SL_IJ = 3'd0;
    localparam logic [2:0] SL_JI = 3'd1;
    localparam logic [2:0] SL_IK = 3'd2;
    localparam logic [2:0] SL_KI = 3'd3;
    localparam logic [2:0] SL_JK = 3'd4;
    localparam logic [2:0] SL_KJ = 3'd5;

    localparam logic [3:0] SLOT_LAST = 4'd5;
    localparam logic [3:0] STEP_LAST = 4'd8;
    localparam logic [3:0] RD_END    = 4'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_PASS,
        ST_TRD,
        ST_CALC,
        ST_TWR,
        ST_NEXT,
        ST_PEND,
        ST_SU,
        ST_SL,
        ST_SC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0] idx;
        logic       chg;
        logic       bad;
    } t_step_st;

endpackage

/* rtl/tbs_req_if.sv */
// ----------------------------------------------------------------------------
// tbs_req_if
// Request channel: write, read or run beats.
// ----------------------------------------------------------------------------
interface tbs_req_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [3:0]                   row;
    logic [3:0]                   col;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, req_type, row, col, value, input ready);
    modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

/* rtl/tbs_rsp_if.sv */
// ----------------------------------------------------------------------------
// tbs_rsp_if
// Response channel: one beat per request.
// ----------------------------------------------------------------------------
interface tbs_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         status;
    logic [3:0]                   pair_first;
    logic [3:0]                   pair_second;
    logic                         all_tight;
    logic                         pair_valid;

    modport source (output valid, read_value, status, pair_first, pair_second,
                    all_tight, pair_valid, input ready);
    modport sink   (input valid, read_value, status, pair_first, pair_second,
                    all_tight, pair_valid, output ready);
endinterface

/* rtl/tbs_mem.sv */
// ----------------------------------------------------------------------------
// tbs_mem
// Bound store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tbs_mem #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [1<<AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

/* rtl/tbs_step.sv */
// ----------------------------------------------------------------------------
// tbs_step
// One triangle step on the cached triple: saturating sum or difference,
// tighten or raise of one entry, and the consistency check.
// ----------------------------------------------------------------------------
module tbs_step #(
    parameter int VB = 32
) (
    input  logic signed [VB-1:0] i_v [6],
    input  logic [3:0]           i_step,
    output logic signed [VB-1:0] o_new,
    output tbs_pkg::t_step_st    o_st
);
    import tbs_pkg::*;

    logic [2:0]          ia, ib, it, il;
    logic                is_sub, is_up;
    logic signed [VB:0]  s;
    logic signed [VB-1:0] d, t;
    logic                chg;

    always_comb begin
        ia = SL_IK; ib = SL_JK; it = SL_IJ; il = SL_JI; is_sub = 1'b0; is_up = 1'b1;
        case (i_step)
            4'd0: begin ia = SL_IK; ib = SL_JK; it = SL_IJ; il = SL_JI; end
            4'd1: begin ia = SL_IJ; ib = SL_JK; it = SL_IK; il = SL_KI; end
            4'd2: begin ia = SL_IJ; ib = SL_IK; it = SL_JK; il = SL_KJ; end
            4'd3: begin ia = SL_KI; ib = SL_JK; it = SL_JI; is_sub = 1'b1; is_up = 1'b0; end
            4'd4: begin ia = SL_KJ; ib = SL_IK; it = SL_JI; is_sub = 1'b1; is_up = 1'b0; end
            4'd5: begin ia = SL_JI; ib = SL_JK; it = SL_KI; is_sub = 1'b1; is_up = 1'b0; end
            4'd6: begin ia = SL_KJ; ib = SL_IJ; it = SL_KI; is_sub = 1'b1; is_up = 1'b0; end
            4'd7: begin ia = SL_JI; ib = SL_IK; it = SL_KJ; is_sub = 1'b1; is_up = 1'b0; end
            4'd8: begin ia = SL_KI; ib = SL_IJ; it = SL_KJ; is_sub = 1'b1; is_up = 1'b0; end
            default: begin ia = SL_IK; end
        endcase
    end

    always_comb begin
        if (is_sub) s = {i_v[ia][VB-1], i_v[ia]} - {i_v[ib][VB-1], i_v[ib]};
        else        s = {i_v[ia][VB-1], i_v[ia]} + {i_v[ib][VB-1], i_v[ib]};
        if (s[VB] != s[VB-1]) d = s[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
        else                  d = s[VB-1:0];
        t   = i_v[it];
        chg = is_up ? (t > d) : (t < d);
        o_new       = chg ? d : t;
        o_st.idx    = it;
        o_st.chg    = chg;
        o_st.bad    = is_up && (i_v[il] > d);
    end
endmodule

/* rtl/triangle_bound_smoothing.sv */
// ----------------------------------------------------------------------------
// triangle_bound_smoothing
// Distance-bound matrix in one synchronous memory with triangle smoothing.
// ----------------------------------------------------------------------------
//  port      dir  beat
//  i_req     in   req_type, row, col, value
//  o_rsp     out  read_value, status, pair_first, pair_second, all_tight,
//                 pair_valid
//  i_cfg_*   in   we, idx, data (matrix_size, max_passes)
//
//  Write: answered on acceptance. Read: answered with registered memory data.
//  Run: per pass, per triple 7 read slots, 9 steps, 6 writebacks, 1 advance,
//  then ST_SU, ST_SL, ST_SC per pair for the gap scan; memory bound. One
//  request in flight; a new beat is taken once the response register is free
//  or drained in the same cycle. Reset clears control state only.
// ----------------------------------------------------------------------------
module triangle_bound_smoothing #(
    parameter int MAX_POINTS = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbs_req_if.sink     i_req,
    tbs_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    import tbs_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int AW = 2 * IW;
    localparam int XW = (IW > 4) ? IW : 4;
    localparam int VB = VALUE_BITS;

    t_state r_state, n_state;

    logic [4:0]  r_msize;
    logic [9:0]  r_maxp, r_pass;
    logic [IW:0] r_n, r_i, r_j, r_k;
    logic [3:0]  r_sub;
    logic        r_chg, r_err, r_found, r_rd_ok;
    logic signed [VB-1:0] r_v [6];
    logic signed [VB-1:0] r_up;
    logic signed [VB:0]   r_best;
    logic [IW-1:0] r_pi, r_pj;

    logic                 r_ov, r_status, r_tight, r_pvalid;
    logic signed [VB-1:0] r_rval;
    logic [3:0]           r_pf, r_ps;

    logic [XW:0] row_x, col_x;
    logic        in_rng, acc, out_free, imm_rsp;
    logic        mem_we;
    logic [AW-1:0] waddr, raddr, slot_addr;
    logic [VB-1:0] wdata, rdata;
    logic [2:0]    slot;
    logic signed [VB-1:0] st_new;
    t_step_st             st;
    logic signed [VB:0]   gap;
    logic                 last_triple_k, last_triple_j, last_triple_i;

    tbs_mem #(.AW(AW), .DW(VB)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    tbs_step #(.VB(VB)) u_step (
        .i_v   (r_v),
        .i_step(r_sub),
        .o_new (st_new),
        .o_st  (st)
    );

    assign row_x    = (XW+1)'(i_req.row);
    assign col_x    = (XW+1)'(i_req.col);
    assign in_rng   = (int'(row_x) < MAX_POINTS) && (int'(col_x) < MAX_POINTS);
    assign out_free = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign acc      = i_req.valid && i_req.ready;
    assign imm_rsp  = acc && (i_req.req_type != REQ_READ) && (i_req.req_type != REQ_RUN);
    assign gap      = {r_up[VB-1], r_up} - {rdata[VB-1], rdata};

    assign last_triple_k = !((r_k + 1'b1) < r_n);
    assign last_triple_j = !((r_j + 2'd2) < r_n);
    assign last_triple_i = !((r_i + 2'd3) < r_n);

    always_comb begin
        slot = r_sub[2:0];
        case (slot)
            SL_IJ:   slot_addr = {r_i[IW-1:0], r_j[IW-1:0]};
            SL_JI:   slot_addr = {r_j[IW-1:0], r_i[IW-1:0]};
            SL_IK:   slot_addr = {r_i[IW-1:0], r_k[IW-1:0]};
            SL_KI:   slot_addr = {r_k[IW-1:0], r_i[IW-1:0]};
            SL_JK:   slot_addr = {r_j[IW-1:0], r_k[IW-1:0]};
            SL_KJ:   slot_addr = {r_k[IW-1:0], r_j[IW-1:0]};
            default: slot_addr = {r_i[IW-1:0], r_j[IW-1:0]};
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        waddr  = slot_addr;
        wdata  = r_v[slot];
        raddr  = slot_addr;
        case (r_state)
            ST_IDLE: begin
                waddr  = {IW'(row_x), IW'(col_x)};
                wdata  = i_req.value;
                raddr  = {IW'(row_x), IW'(col_x)};
                mem_we = acc && (i_req.req_type == REQ_WRITE) && in_rng;
            end
            ST_TWR:  mem_we = 1'b1;
            ST_SU:   raddr = {r_i[IW-1:0], r_j[IW-1:0]};
            ST_SL:   raddr = {r_j[IW-1:0], r_i[IW-1:0]};
            default: mem_we = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_req.req_type == REQ_READ) n_state = ST_RD;
                else if (acc && i_req.req_type == REQ_RUN) n_state = ST_PASS;
            end
            ST_RD:   n_state = ST_IDLE;
            ST_PASS: n_state = (r_n >= 3) ? ST_TRD : ST_PEND;
            ST_TRD:  n_state = (r_sub == RD_END) ? ST_CALC : ST_TRD;
            ST_CALC: begin
                if (st.bad || r_sub == STEP_LAST) n_state = ST_TWR;
            end
            ST_TWR: begin
                if (r_sub == SLOT_LAST) n_state = r_err ? ST_DONE : ST_NEXT;
            end
            ST_NEXT: begin
                if (last_triple_k && last_triple_j && last_triple_i) n_state = ST_PEND;
                else n_state = ST_TRD;
            end
            ST_PEND: begin
                if (!r_chg || r_pass >= r_maxp) n_state = (r_n >= 2) ? ST_SU : ST_DONE;
                else n_state = ST_PASS;
            end
            ST_SU:   n_state = ST_SL;
            ST_SL:   n_state = ST_SC;
            ST_SC: begin
                if (!((r_j + 1'b1) < r_n) && !((r_i + 2'd2) < r_n)) n_state = ST_DONE;
                else n_state = ST_SU;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_msize <= MSIZE_RESET;
            r_maxp  <= MAXP_RESET;
            r_pass  <= '0;
            r_ov    <= 1'b0;
            r_err   <= 1'b0;
            r_chg   <= 1'b0;
            r_found <= 1'b0;
            r_sub   <= '0;
            r_best  <= '1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MSIZE) r_msize <= i_cfg_data[4:0];
                else                        r_maxp  <= i_cfg_data;
            end
            if (r_ov && o_rsp.ready && !imm_rsp) r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_rd_ok <= in_rng;
                    r_err   <= 1'b0;
                    r_pass  <= '0;
                    r_n     <= (int'(r_msize) > MAX_POINTS) ? (IW+1)'(MAX_POINTS)
                                                             : (IW+1)'(r_msize);
                    if (imm_rsp) begin
                        r_ov     <= 1'b1;
                        r_rval   <= '0;
                        r_status <= 1'b0;
                        r_pf     <= '0;
                        r_ps     <= '0;
                        r_tight  <= 1'b0;
                        r_pvalid <= 1'b0;
                    end
                end
                ST_RD: begin
                    r_ov     <= 1'b1;
                    r_rval   <= r_rd_ok ? rdata : '0;
                    r_status <= 1'b0;
                    r_pf     <= '0;
                    r_ps     <= '0;
                    r_tight  <= 1'b0;
                    r_pvalid <= 1'b0;
                end
                ST_PASS: begin
                    r_i   <= '0;
                    r_j   <= (IW+1)'(1);
                    r_k   <= (IW+1)'(2);
                    r_chg <= 1'b0;
                    r_sub <= '0;
                end
                ST_TRD: begin
                    if (r_sub != '0) r_v[r_sub[2:0] - 3'd1] <= rdata;
                    r_sub <= (r_sub == RD_END) ? '0 : r_sub + 1'b1;
                end
                ST_CALC: begin
                    r_v[st.idx] <= st_new;
                    if (st.chg) r_chg <= 1'b1;
                    if (st.bad) r_err <= 1'b1;
                    r_sub <= (st.bad || r_sub == STEP_LAST) ? '0 : r_sub + 1'b1;
                end
                ST_TWR: r_sub <= (r_sub == SLOT_LAST) ? '0 : r_sub + 1'b1;
                ST_NEXT: begin
                    if (!last_triple_k) begin
                        r_k <= r_k + 1'b1;
                    end else if (!last_triple_j) begin
                        r_j <= r_j + 1'b1;
                        r_k <= r_j + 2'd2;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 2'd2;
                        r_k <= r_i + 2'd3;
                    end
                end
                ST_PEND: begin
                    if (r_chg && r_pass < r_maxp) r_pass <= r_pass + 1'b1;
                    r_i     <= '0;
                    r_j     <= (IW+1)'(1);
                    r_best  <= '1;
                    r_found <= 1'b0;
                end
                ST_SL: r_up <= rdata;
                ST_SC: begin
                    if (gap > r_best) begin
                        r_best  <= gap;
                        r_pi    <= r_i[IW-1:0];
                        r_pj    <= r_j[IW-1:0];
                        r_found <= 1'b1;
                    end
                    if ((r_j + 1'b1) < r_n) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 2'd2;
                    end
                end
                ST_DONE: begin
                    r_ov     <= 1'b1;
                    r_rval   <= '0;
                    r_status <= r_err;
                    r_pvalid <= !r_err && r_found;
                    r_tight  <= !r_err && r_found && (r_best == '0);
                    r_pf     <= (!r_err && r_found) ? 4'(r_pi) : 4'd0;
                    r_ps     <= (!r_err && r_found) ? 4'(r_pj) : 4'd0;
                end
                default: r_sub <= r_sub;
            endcase
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.read_value  = r_rval;
    assign o_rsp.status      = r_status;
    assign o_rsp.pair_first  = r_pf;
    assign o_rsp.pair_second = r_ps;
    assign o_rsp.all_tight   = r_tight;
    assign o_rsp.pair_valid  = r_pvalid;

    `TBS_ASSERT(a_err_nopair, o_rsp.valid && o_rsp.status, !o_rsp.pair_valid && !o_rsp.all_tight, "error beat carries a pair")
    `TBS_ASSERT(a_tight_pair, o_rsp.valid && o_rsp.all_tight, o_rsp.pair_valid, "tight without pair")
    `TBS_ASSERT(a_trd_sub, r_state == ST_TRD, r_sub <= RD_END, "triple read slot overrun")
    `TBS_ASSERT_NEXT(a_done_idle, r_state == ST_DONE, r_state == ST_IDLE && o_rsp.valid, "run end lost")
endmodule
